>>> sv/ihex_pkg.sv
package ihex_pkg;

	localparam int RECORD_BYTES = 16;
	localparam int IDX_W        = $clog2(RECORD_BYTES + 1);
	localparam logic [7:0] COUNT_BYTE = 8'(RECORD_BYTES);

	localparam int ADDR_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRLF  = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_LF    = 7'h0A;

	// character positions within one transaction's output
	typedef logic [3:0] step_t;
	localparam step_t ST_COLON  = 4'd0;
	localparam step_t ST_CNT_H  = 4'd1;
	localparam step_t ST_CNT_L  = 4'd2;
	localparam step_t ST_ADDR_3 = 4'd3;
	localparam step_t ST_ADDR_2 = 4'd4;
	localparam step_t ST_ADDR_1 = 4'd5;
	localparam step_t ST_ADDR_0 = 4'd6;
	localparam step_t ST_TYPE_H = 4'd7;
	localparam step_t ST_TYPE_L = 4'd8;
	localparam step_t ST_DATA_H = 4'd9;
	localparam step_t ST_DATA_L = 4'd10;
	localparam step_t ST_CK_H   = 4'd11;
	localparam step_t ST_CK_L   = 4'd12;
	localparam step_t ST_CR     = 4'd13;
	localparam step_t ST_LF     = 4'd14;

	typedef struct packed {
		logic              eof;
		logic              hdr;
		logic              tail;
		logic              crlf;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic [7:0]        cksum;
	} cmd_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10)
			c = 7'h30 + {3'b000, nib};
		else
			c = 7'h37 + {3'b000, nib};
		return c;
	endfunction

	// ":00000001FF", indexed by position
	function automatic logic [6:0] eof_char(input step_t pos);
		logic [6:0] c;
		unique case (pos)
			4'd0:                 c = CH_COLON;
			4'd8:                 c = 7'h31;
			4'd9, 4'd10:          c = 7'h46;
			default:              c = CH_ZERO;
		endcase
		return c;
	endfunction

endpackage

>>> sv/ihex_if.sv
interface ihex_feed_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source(output valid, mode, data_byte, input ready);
	modport sink(input valid, mode, data_byte, output ready);
endinterface

interface ihex_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] text_char;
	logic       last_of_run;

	modport source(output valid, text_char, last_of_run, input ready);
	modport sink(input valid, text_char, last_of_run, output ready);
endinterface

>>> sv/intel_hex_record_encoder_core.sv
// Intel HEX encoder: each accepted data byte (mode 0) yields its two uppercase hex digits;
// the first byte of a 16-byte record is preceded by ":10", the four-digit address and "00",
// and the sixteenth is followed by the checksum and a line end (CR LF or LF, per
// CFG_CRLF). A finish item (mode 1) drops any partial record and yields ":00000001FF"
// and a line end, then rewinds the address to the CFG_START value. last_of_run marks
// the final character of each input item. Characters leave at one per cycle from the
// output register while the receiver is ready and a command is queued; a record is
// 45 (or 44) characters and an end-of-file record 13 (or 12). Items are accepted while
// the 4-entry command queue between the input stage and the character sequencer has
// room; output back-pressure stalls only the sequencer until the queue fills. Write
// configuration only while the block is idle.
module intel_hex_record_encoder_core
	import ihex_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ihex_feed_if.sink             feed,
	ihex_text_if.source           text
);

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	assign feed.ready = !full;
	assign push       = feed.valid && !full;

	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.mode      (feed.mode),
		.data_byte (feed.data_byte),
		.cmd       (push_cmd)
	);

	ihex_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.out_char  (text.text_char),
		.out_last  (text.last_of_run)
	);

endmodule

>>> sv/ihex_front.sv
module ihex_front
	import ihex_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	input  logic                  mode,
	input  logic [7:0]            data_byte,
	output cmd_t                  cmd
);

	logic [ADDR_W-1:0] start_q;
	logic              crlf_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        sum_q;

	logic       hdr;
	logic       tail;
	logic [7:0] base_sum;
	logic [7:0] new_sum;

	assign hdr      = (idx_q == '0);
	assign tail     = (idx_q + IDX_W'(1)) == IDX_W'(RECORD_BYTES);
	assign base_sum = hdr ? (COUNT_BYTE + addr_q[15:8] + addr_q[7:0]) : sum_q;
	assign new_sum  = base_sum + data_byte;

	always_comb begin
		cmd.eof   = mode;
		cmd.hdr   = hdr;
		cmd.tail  = tail;
		cmd.crlf  = crlf_q;
		cmd.addr  = addr_q;
		cmd.data  = data_byte;
		cmd.cksum = ~new_sum + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			crlf_q  <= 1'b1;
			addr_q  <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START: begin
					start_q <= cfg_wdata;
					if (idx_q == '0)
						addr_q <= cfg_wdata;
				end
				CFG_CRLF: crlf_q <= cfg_wdata[0];
			endcase
		end else if (push) begin
			if (mode) begin
				// drop any partial record and rewind for a new file
				addr_q <= start_q;
				idx_q  <= '0;
				sum_q  <= '0;
			end else if (tail) begin
				addr_q <= addr_q + ADDR_W'(RECORD_BYTES);
				idx_q  <= '0;
				sum_q  <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				sum_q <= new_sum;
			end
		end
	end

endmodule

>>> sv/ihex_fifo.sv
module ihex_fifo
	import ihex_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PTR_W'(1);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("transaction queued into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from an empty queue");
`endif

endmodule

>>> sv/ihex_back.sv
module ihex_back
	import ihex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  out_char,
	output logic        out_last
);

	logic       busy_q;
	step_t      step_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic       advance;
	logic       fire;
	step_t      cur_step;
	step_t      next_step;
	logic       is_last;
	logic [6:0] cur_char;

	assign advance  = !valid_q || out_ready;
	assign fire     = advance && !empty;
	assign cur_step = busy_q ? step_q : ((head.eof || head.hdr) ? ST_COLON : ST_DATA_H);
	assign pop      = fire && is_last;

	always_comb begin
		next_step = cur_step + step_t'(1);
		is_last   = 1'b0;
		unique case (cur_step)
			ST_DATA_L: begin
				if (head.eof)
					next_step = head.crlf ? ST_CR : ST_LF;
				else if (head.tail)
					next_step = ST_CK_H;
				else
					is_last = 1'b1;
			end
			ST_CK_L: next_step = head.crlf ? ST_CR : ST_LF;
			ST_LF:   is_last = 1'b1;
			default: next_step = cur_step + step_t'(1);
		endcase
	end

	always_comb begin
		if (head.eof && cur_step <= ST_DATA_L) begin
			cur_char = eof_char(cur_step);
		end else begin
			unique case (cur_step)
				ST_COLON:  cur_char = CH_COLON;
				ST_CNT_H:  cur_char = hex_char(COUNT_BYTE[7:4]);
				ST_CNT_L:  cur_char = hex_char(COUNT_BYTE[3:0]);
				ST_ADDR_3: cur_char = hex_char(head.addr[15:12]);
				ST_ADDR_2: cur_char = hex_char(head.addr[11:8]);
				ST_ADDR_1: cur_char = hex_char(head.addr[7:4]);
				ST_ADDR_0: cur_char = hex_char(head.addr[3:0]);
				ST_DATA_H: cur_char = hex_char(head.data[7:4]);
				ST_DATA_L: cur_char = hex_char(head.data[3:0]);
				ST_CK_H:   cur_char = hex_char(head.cksum[7:4]);
				ST_CK_L:   cur_char = hex_char(head.cksum[3:0]);
				ST_CR:     cur_char = CH_CR;
				ST_LF:     cur_char = CH_LF;
				default:   cur_char = CH_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= ST_COLON;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= !empty;
			if (fire) begin
				busy_q <= !is_last;
				step_q <= next_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			char_q <= cur_char;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

`ifndef SYNTH
	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !empty)
		else $error("sequencer mid-transaction with no queued command");

	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (char_q != CH_CR && char_q != CH_COLON))
		else $error("run ends on a carriage return or a record mark");
`endif

endmodule

>>> test/testbench.sv
module testbench;
	import ihex_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 140;
	localparam int SETTLE_CYCLES = 6;

	localparam logic [6:0] ASCII_COLON = 7'h3A;
	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_UPPER = 7'h41;
	localparam logic [6:0] ASCII_CR    = 7'h0D;
	localparam logic [6:0] ASCII_LF    = 7'h0A;

	localparam logic MODE_DATA   = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	typedef struct packed {
		logic [6:0] text_char;
		logic       last_of_run;
	} text_beat_t;

	class hex_text_scoreboard;
		logic [15:0] start_addr;
		logic        crlf;
		logic [15:0] rec_addr;
		int unsigned fill;
		logic [7:0]  sum;
		text_beat_t  text_due_q[$];
		logic [6:0]  run_chars[$];
		int unsigned errors;

		function new();
			start_addr = '0;
			crlf       = 1'b1;
			rec_addr   = '0;
			fill       = 0;
			sum        = '0;
			errors     = 0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_START) begin
				start_addr = val[15:0];
				if (fill == 0)
					rec_addr = start_addr;
			end else if (idx == CFG_CRLF) begin
				crlf = val[0];
			end
		endfunction

		function logic [6:0] nibble_char(logic [3:0] nib);
			if (nib < 4'd10)
				return ASCII_ZERO + 7'(nib);
			return ASCII_UPPER + 7'(nib - 4'd10);
		endfunction

		function void add_hex(logic [7:0] v);
			run_chars.push_back(nibble_char(v[7:4]));
			run_chars.push_back(nibble_char(v[3:0]));
		endfunction

		function void add_line_end();
			if (crlf)
				run_chars.push_back(ASCII_CR);
			run_chars.push_back(ASCII_LF);
		endfunction

		// work out the characters one accepted item produces
		function void encode_item(logic mode, logic [7:0] data_byte);
			text_beat_t beat;
			run_chars.delete();
			if (mode == MODE_FINISH) begin
				run_chars.push_back(ASCII_COLON);
				add_hex(8'h00);
				add_hex(8'h00);
				add_hex(8'h00);
				add_hex(8'h01);
				add_hex(8'hFF);
				add_line_end();
				rec_addr = start_addr;
				fill     = 0;
				sum      = '0;
			end else begin
				if (fill == 0) begin
					run_chars.push_back(ASCII_COLON);
					add_hex(COUNT_BYTE);
					add_hex(rec_addr[15:8]);
					add_hex(rec_addr[7:0]);
					add_hex(8'h00);
					sum = COUNT_BYTE + rec_addr[15:8] + rec_addr[7:0];
				end
				add_hex(data_byte);
				sum  = sum + data_byte;
				fill = fill + 1;
				if (fill >= RECORD_BYTES) begin
					add_hex(8'(0 - sum));
					add_line_end();
					rec_addr = rec_addr + 16'(RECORD_BYTES);
					fill     = 0;
					sum      = '0;
				end
			end
			foreach (run_chars[i]) begin
				beat.text_char   = run_chars[i];
				beat.last_of_run = (i == run_chars.size() - 1);
				text_due_q.push_back(beat);
			end
		endfunction

		function void compare_char(logic [6:0] text_char, logic last_of_run);
			text_beat_t due;
			if (text_due_q.size() == 0) begin
				$error("unexpected character: text_char %h last_of_run %b", text_char,
					last_of_run);
				errors++;
				return;
			end
			due = text_due_q.pop_front();
			if (text_char !== due.text_char) begin
				$error("text_char: expected %h, got %h", due.text_char, text_char);
				errors++;
			end
			if (last_of_run !== due.last_of_run) begin
				$error("last_of_run: expected %b, got %b", due.last_of_run, last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ihex_feed_if feed_ch();
	ihex_text_if text_ch();

	intel_hex_record_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.feed      (feed_ch.sink),
		.text      (text_ch.source)
	);

	hex_text_scoreboard sb = new();
	int unsigned feed_idle_pct = 13;
	int unsigned text_idle_pct = 65;
	int unsigned cycle_count   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		text_ch.ready <= ($urandom_range(99) >= text_idle_pct);
	end

	// note inputs before checking outputs of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (feed_ch.valid && feed_ch.ready)
				sb.encode_item(feed_ch.mode, feed_ch.data_byte);
			if (text_ch.valid && text_ch.ready)
				sb.compare_char(text_ch.text_char, text_ch.last_of_run);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("intel_hex_record_encoder_core test failed");
			$finish;
		end
	end

	task automatic push_item(input logic mode, input logic [7:0] data_byte);
		while ($urandom_range(99) < feed_idle_pct) begin
			feed_ch.valid <= 1'b0;
			@(posedge clk);
		end
		feed_ch.valid     <= 1'b1;
		feed_ch.mode      <= mode;
		feed_ch.data_byte <= data_byte;
		do
			@(posedge clk);
		while (!feed_ch.ready);
	endtask

	// drop valid and hold until every expected character has come out
	task automatic wait_drained();
		feed_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.text_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.apply_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		static logic [7:0] record_bytes[16] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hA5,
			8'h5A, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h99, 8'h66, 8'h10, 8'hEF, 8'h09};
		static int unsigned feed_pcts[3] = '{13, 65, 0};
		static int unsigned text_pcts[3] = '{65, 13, 0};
		logic [15:0] phase_starts[3];
		static logic phase_crlf[3] = '{1'b1, 1'b0, 1'b1};

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_START;
		cfg_wdata         <= '0;
		feed_ch.valid     <= 1'b0;
		feed_ch.mode      <= MODE_DATA;
		feed_ch.data_byte <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end-of-file with nothing open, then one full record at the reset address
		push_item(MODE_FINISH, 8'($urandom_range(255)));
		foreach (record_bytes[i])
			push_item(MODE_DATA, record_bytes[i]);
		wait_drained();

		// LF only, top address loads at once since no record is open
		write_reg(CFG_CRLF, 16'h0000);
		write_reg(CFG_START, 16'hFFFF);
		push_item(MODE_DATA, 8'hFF);
		push_item(MODE_DATA, 8'h00);
		push_item(MODE_DATA, 8'hAB);
		wait_drained();

		// record open: new start address waits for the finish, which drops the partial record
		write_reg(CFG_START, 16'h1234);
		push_item(MODE_FINISH, 8'h00);
		push_item(MODE_DATA, 8'h4E);
		push_item(MODE_DATA, 8'hB1);
		push_item(MODE_FINISH, 8'hFF);
		wait_drained();

		phase_starts[0] = 16'($urandom_range(65535));
		phase_starts[1] = 16'hFFF0;
		phase_starts[2] = 16'h0000;
		for (int p = 0; p < 3; p++) begin
			feed_idle_pct = feed_pcts[p];
			text_idle_pct = text_pcts[p];
			write_reg(CFG_CRLF, {15'b0, phase_crlf[p]});
			write_reg(CFG_START, phase_starts[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(39) == 0)
					push_item(MODE_FINISH, 8'($urandom_range(255)));
				else
					push_item(MODE_DATA, 8'($urandom_range(255)));
			end
			wait_drained();
		end

		if (sb.errors == 0 && sb.text_due_q.size() == 0)
			$display("intel_hex_record_encoder_core test passed");
		else
			$display("intel_hex_record_encoder_core test failed");
		$finish;
	end
endmodule

>>> sim.f
sv/ihex_pkg.sv
sv/ihex_if.sv
sv/ihex_front.sv
sv/ihex_fifo.sv
sv/ihex_back.sv
sv/intel_hex_record_encoder_core.sv
test/testbench.sv
